@@ hdl/tss_pkg.sv @@
// Package: shared constants and types for the triangle sphere subdivider.
`default_nettype none
package tss_pkg;
    localparam int MAX_DEPTH  = 3;
    localparam int COORD_BITS = 16;
    localparam int FRAC_EXT   = MAX_DEPTH;
    localparam int CW         = COORD_BITS + FRAC_EXT;   // widened signed coordinate
    localparam int MW         = CW;                      // magnitude width
    localparam int SW         = 2 * MW + 2;              // squared-length width
    localparam int RW         = 15;                      // result magnitude 0..16384
    localparam int UNIT_ONE   = 16384;
    localparam int OUT_W      = 16;
    localparam int LEAF_W     = 2 * MAX_DEPTH;

    typedef logic signed [CW-1:0] t_coord;
    typedef t_coord t_vec [3];
    typedef t_vec   t_tri [3];
endpackage
`default_nettype wire

@@ hdl/tss_norm.sv @@
// Module: shared normalizer, one bit of the rounded unit component per step.
`default_nettype none
module tss_norm
    import tss_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [MW-1:0]        i_mag,
    input  wire logic [SW-1:0]        i_sum,
    output logic                      o_done,
    output logic [RW-1:0]             o_res
);
    // Find largest r <= 16384 with (2r-1)^2 * S <= m^2 * 2^30.
    localparam int KW = RW + 1;
    localparam int PW = 2 * KW + SW;
    localparam int BC = $clog2(RW + 1);
    localparam int HW = SW / 2;

    logic [RW-1:0]  r_res, n_res;
    logic [BC-1:0]  r_bit, n_bit;
    logic           r_busy, n_busy, r_done, n_done;
    logic [1:0]     r_ph, n_ph;
    logic [KW-1:0]  r_k;
    logic [2*KW-1:0] r_kk;
    logic [2*KW+HW-1:0]    r_plo;
    logic [2*KW+SW-HW-1:0] r_phi;
    logic [2*MW-1:0] r_m2;
    logic [PW-1:0]  w_lhs;
    logic [PW-1:0]  w_rhs;
    logic [RW-1:0]  w_try;

    // product split in two halves of the squared length
    assign w_lhs = (PW'(r_phi) << HW) + PW'(r_plo);
    assign w_rhs = PW'({r_m2, 30'd0});
    assign w_try = r_res | (RW'(1) << r_bit);

    always_comb begin
        n_res  = r_res;
        n_bit  = r_bit;
        n_busy = r_busy;
        n_done = 1'b0;
        n_ph   = r_ph;
        if (i_start) begin
            n_res  = '0;
            n_bit  = BC'(RW - 1);
            n_busy = (i_sum != '0);
            n_done = (i_sum == '0);
            n_ph   = 2'd0;
        end else if (r_busy) begin
            n_ph = r_ph + 2'd1;
            if (r_ph == 2'd3) begin
                n_ph = 2'd0;
                if (w_try <= RW'(UNIT_ONE) && w_lhs <= w_rhs) n_res = w_try;
                if (r_bit == '0) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end else begin
                    n_bit = r_bit - BC'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_ph   <= n_ph;
        end
        r_res <= n_res;
        r_bit <= n_bit;
        r_k   <= {w_try, 1'b0} - KW'(1);
        r_kk  <= r_k * r_k;
        r_m2  <= i_mag * i_mag;
        r_plo <= r_kk * i_sum[HW-1:0];
        r_phi <= r_kk * i_sum[SW-1:HW];
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule
`default_nettype wire

@@ hdl/triangle_sphere_subdivider.sv @@
// Top level: triangle subdivider with shared normalizer and output register.
// Each transfer in yields 4^depth leaf transfers out, depth-first. Each leaf
// runs nine normalizations through one bit-serial unit (15 result bits),
// and a normalization finishes early when its corner is zero. The input is
// not ready until the last leaf has been loaded into the output register.
`default_nettype none
module triangle_sphere_subdivider
    import tss_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_wdata,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // corner_a_x,y,z, corner_b_x,y,z, corner_c_x,y,z
    input  wire logic [143:0]  s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // unit_a_x,y,z, unit_b_x,y,z, unit_c_x,y,z
    output logic [143:0]       m_axis_tdata,
    output logic               m_axis_tlast
);
    localparam logic [2:0] S_IDLE = 3'd0, S_SPLIT = 3'd1, S_SQ = 3'd2,
                           S_NORM = 3'd3, S_OUT = 3'd4;

    logic [2:0]        r_st;
    logic [1:0]        r_depth, r_dcur;
    logic [1:0]        r_lvl;
    logic [LEAF_W-1:0] r_leaf;
    t_tri              r_lc [MAX_DEPTH+1];
    logic [1:0]        r_ci, r_ki;
    logic [SW-1:0]     r_sum;
    logic [OUT_W-1:0]  r_out [9];
    logic              r_ov, r_olast;
    logic              r_start;

    t_coord            w_p [3][3];
    t_vec              w_v;
    logic [MW-1:0]     w_mag [3];
    logic [MW-1:0]     w_cm;
    logic              w_done;
    logic [RW-1:0]     w_res;
    logic [1:0]        w_child;
    logic [3:0]        w_cnt;
    logic              w_lastleaf;
    t_tri              w_q;

    always_comb begin
        for (int c = 0; c < 3; c++)
            for (int k = 0; k < 3; k++)
                w_p[c][k] = r_lc[r_lvl][c][k];
        w_child = r_leaf[2*(r_dcur-2'd1-r_lvl) +: 2];
        for (int k = 0; k < 3; k++) begin
            t_coord ab, bc, ca;
            ab = t_coord'((CW+1)'(signed'(w_p[0][k])) + (CW+1)'(signed'(w_p[1][k])) >>> 1);
            bc = t_coord'((CW+1)'(signed'(w_p[1][k])) + (CW+1)'(signed'(w_p[2][k])) >>> 1);
            ca = t_coord'((CW+1)'(signed'(w_p[2][k])) + (CW+1)'(signed'(w_p[0][k])) >>> 1);
            unique case (w_child)
                2'd0: begin w_q[0][k] = w_p[0][k]; w_q[1][k] = ab; w_q[2][k] = ca; end
                2'd1: begin w_q[0][k] = w_p[1][k]; w_q[1][k] = bc; w_q[2][k] = ab; end
                2'd2: begin w_q[0][k] = w_p[2][k]; w_q[1][k] = ca; w_q[2][k] = bc; end
                default: begin w_q[0][k] = ab; w_q[1][k] = bc; w_q[2][k] = ca; end
            endcase
        end
        w_v = r_lc[r_dcur][r_ci];
        for (int k = 0; k < 3; k++)
            w_mag[k] = w_v[k][CW-1] ? MW'(-w_v[k]) : MW'(w_v[k]);
        w_cm = w_mag[r_ki];
        w_cnt = 4'(r_ci) * 4'd3 + 4'(r_ki);
        w_lastleaf = (r_leaf == LEAF_W'((1 << (2*r_dcur)) - 1));
    end

    tss_norm u_norm (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_mag(w_cm), .i_sum(r_sum), .o_done(w_done), .o_res(w_res)
    );

    assign s_axis_tready = (r_st == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_depth <= '0;
            r_ov    <= 1'b0;
            r_start <= 1'b0;
        end else begin
            r_start <= (r_st == S_SQ) || (r_st == S_NORM && w_done && r_ki != 2'd2);
            if (i_cfg_we) r_depth <= i_cfg_wdata;
            if (m_axis_tvalid && m_axis_tready && r_st != S_OUT) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: if (s_axis_tvalid) begin
                    for (int c = 0; c < 3; c++)
                        for (int k = 0; k < 3; k++)
                            r_lc[0][c][k] <= t_coord'(signed'(
                                s_axis_tdata[(c*3+k)*16 +: COORD_BITS])) <<< FRAC_EXT;
                    r_dcur <= r_depth;
                    r_leaf <= '0;
                    r_lvl  <= '0;
                    r_st   <= S_SPLIT;
                end
                S_SPLIT: begin
                    if (r_lvl == r_dcur) begin
                        r_ci <= '0; r_ki <= '0; r_st <= S_SQ;
                    end else begin
                        r_lc[r_lvl + 2'd1] <= w_q;
                        r_lvl <= r_lvl + 2'd1;
                    end
                end
                S_SQ: begin
                    r_sum <= SW'(w_mag[0]*w_mag[0]) + SW'(w_mag[1]*w_mag[1])
                           + SW'(w_mag[2]*w_mag[2]);
                    r_st <= S_NORM;
                end
                S_NORM: if (w_done) begin
                    r_out[w_cnt] <= w_v[r_ki][CW-1] ? OUT_W'(-{1'b0, w_res})
                                                   : OUT_W'(w_res);
                    if (r_ki == 2'd2) begin
                        r_ki <= '0;
                        if (r_ci == 2'd2) r_st <= S_OUT;
                        else begin r_ci <= r_ci + 2'd1; r_st <= S_SQ; end
                    end else begin
                        r_ki <= r_ki + 2'd1;
                    end
                end
                S_OUT: if (!r_ov || m_axis_tready) begin
                    r_ov    <= 1'b1;
                    r_olast <= w_lastleaf;
                    for (int i = 0; i < 9; i++) m_axis_tdata[i*16 +: 16] <= r_out[i];
                    if (w_lastleaf) r_st <= S_IDLE;
                    else begin
                        r_leaf <= r_leaf + LEAF_W'(1);
                        r_lvl  <= '0;
                        r_st   <= S_SPLIT;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tlast  = r_olast;
endmodule
`default_nettype wire
